@@ sv/lag_pkg.sv @@
// Shared types and constants for the toroidal life automaton.
// Used by life_automaton_generation; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package lag_pkg;

    // Stream and configuration widths
    localparam int IN_DATA_W  = 16;
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = 8;
    localparam int COORD_W    = 5;
    localparam int CFG_W      = 4;
    localparam int CFG_IDX_W  = 2;

    // Request kinds carried on the input tuser
    typedef enum logic [1:0] {
        FUNC_WRITE   = 2'd0,
        FUNC_READ    = 2'd1,
        FUNC_ADVANCE = 2'd2
    } func_t;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_LONELY = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CROWD  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BIRTH  = 2'd2;

    // Configuration reset values
    localparam logic [CFG_W-1:0] LONELY_RESET = 4'd1;
    localparam logic [CFG_W-1:0] CROWD_RESET  = 4'd4;
    localparam logic [CFG_W-1:0] BIRTH_RESET  = 4'd3;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_CELL = 3'b010,
        ST_GEN  = 3'b100
    } state_t;

    // Survival and birth thresholds
    typedef struct packed {
        logic [CFG_W-1:0] lonely;
        logic [CFG_W-1:0] crowd;
        logic [CFG_W-1:0] birth;
    } rule_cfg_t;

endpackage

`default_nettype wire

@@ sv/lag_ram.sv @@
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module lag_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

@@ sv/life_automaton_generation.sv @@
// Toroidal life automaton: cell write/read and whole-grid generation step.
// Depends on lag_pkg and lag_ram (one row of the grid per RAM word).
//
//  channel   | direction | handshake                   | content
//  ----------+-----------+-----------------------------+------------------------------
//  cfg       | in        | cfg_we                      | cfg_index, cfg_data (4 bits)
//  s_axis    | in        | s_axis_tvalid/s_axis_tready | request: kind, row, column
//  m_axis    | out       | m_axis_tvalid/m_axis_tready | result: cell_state, op_done
//
// Cell write or read, per request: row read, modify/write back or bit pick, result
// staging. Generation: the sweep reads one row per cycle, writes each updated row
// back once the row after it has been read, and keeps three rows in registers.
// Reset clears the row valid bits, so every row reads as dead until written.
// A finished result waits in an output register; the next request is taken
// while it waits, and the sequencer holds a further result until it drains.
`timescale 1ns / 1ps
`default_nettype none

module life_automaton_generation #(
    parameter int SIDE = 32
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_we,
    input  wire logic [lag_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [lag_pkg::CFG_W-1:0]          cfg_data,
    input  wire logic                               s_axis_tvalid,
    output logic                                    s_axis_tready,
    // [4:0] row, [9:5] column, [10] cell_value, [15:11] zero
    input  wire logic [lag_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    // [1:0] func
    input  wire logic [lag_pkg::IN_USER_W-1:0]      s_axis_tuser,
    output logic                                    m_axis_tvalid,
    input  wire logic                               m_axis_tready,
    // [0] cell_state, [1] op_done, [7:2] zero
    output logic [lag_pkg::OUT_DATA_W-1:0]          m_axis_tdata
);

    localparam int AW = $clog2(SIDE);
    localparam int CW = $clog2(SIDE + 3);
    localparam logic [CW-1:0] GEN_LAST = CW'(SIDE + 2);
    localparam logic [CW-1:0] GEN_SIDE = CW'(SIDE);
    localparam logic [AW-1:0] ROW_LAST = AW'(SIDE - 1);

    // Control registers
    lag_pkg::state_t     state_reg, state_next;
    logic [CW-1:0]       gen_cnt_reg, gen_cnt_next;
    logic                res_pending_reg, res_pending_next;
    logic                out_valid_reg, out_valid_next;
    logic                rd_valid_reg;
    logic [SIDE-1:0]     valid_reg;
    lag_pkg::rule_cfg_t  rule_reg;

    // Payload registers
    logic                op_write_reg, op_write_next;
    logic [AW-1:0]       row_reg, row_next;
    logic [AW-1:0]       col_reg, col_next;
    logic                val_reg, val_next;
    logic                res_state_reg, res_state_next;
    logic                res_done_reg, res_done_next;
    logic                out_state_reg, out_state_next;
    logic                out_done_reg, out_done_next;
    logic [SIDE-1:0]     prev_reg, prev_next;
    logic [SIDE-1:0]     cur_reg, cur_next;
    logic [SIDE-1:0]     row0_reg, row0_next;

    // Memory port signals
    logic                mem_we;
    logic [AW-1:0]       mem_waddr;
    logic [SIDE-1:0]     mem_wdata;
    logic [AW-1:0]       mem_raddr;
    logic [SIDE-1:0]     mem_rdata;

    // Datapath signals
    logic                accept;
    lag_pkg::func_t      func_in;
    logic [lag_pkg::COORD_W-1:0] row_in;
    logic [lag_pkg::COORD_W-1:0] col_in;
    logic                val_in;
    logic                on_grid;
    logic [SIDE-1:0]     row_data;
    logic [SIDE-1:0]     next_row;
    logic [SIDE-1:0]     new_row;
    logic [SIDE-1:0]     cell_row;

    // Unpack the request
    assign func_in = lag_pkg::func_t'(s_axis_tuser);
    assign row_in  = s_axis_tdata[4:0];
    assign col_in  = s_axis_tdata[9:5];
    assign val_in  = s_axis_tdata[10];
    assign on_grid = (32'(row_in) < 32'(SIDE)) && (32'(col_in) < 32'(SIDE));

    assign s_axis_tready = (state_reg == lag_pkg::ST_IDLE) && !res_pending_reg;
    assign accept        = s_axis_tvalid && s_axis_tready;

    // Grid storage, one row per word
    lag_ram #(
        .WIDTH (SIDE),
        .DEPTH (SIDE)
    ) u_grid (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // Rows never written since reset read as dead
    assign row_data = mem_rdata & {SIDE{rd_valid_reg}};

    // The last row of a sweep wraps to the saved copy of the old first row
    assign next_row = (gen_cnt_reg == GEN_LAST) ? row0_reg : row_data;

    // Select the read row
    always_comb
    begin
        case (state_reg)
            lag_pkg::ST_IDLE: mem_raddr = AW'(row_in);
            lag_pkg::ST_CELL: mem_raddr = row_reg;
            lag_pkg::ST_GEN:
            begin
                if (gen_cnt_reg == '0)
                begin
                    mem_raddr = ROW_LAST;
                end
                else
                begin
                    mem_raddr = AW'(gen_cnt_reg - CW'(1));
                end
            end
            default: mem_raddr = row_reg;
        endcase
    end

    // Apply the rule to every column of the middle row
    always_comb
    begin
        logic [3:0] cnt;
        int yl;
        int yr;
        for (int y = 0; y < SIDE; y++)
        begin
            yl = (y == 0) ? SIDE - 1 : y - 1;
            yr = (y == SIDE - 1) ? 0 : y + 1;
            cnt = 4'(prev_reg[yl]) + 4'(prev_reg[y]) + 4'(prev_reg[yr])
                + 4'(cur_reg[yl]) + 4'(cur_reg[yr])
                + 4'(next_row[yl]) + 4'(next_row[y]) + 4'(next_row[yr]);
            if (cur_reg[y])
            begin
                new_row[y] = !((cnt <= rule_reg.lonely) || (cnt >= rule_reg.crowd));
            end
            else
            begin
                new_row[y] = (cnt == rule_reg.birth);
            end
        end
    end

    // Merge one cell into the fetched row
    always_comb
    begin
        cell_row          = row_data;
        cell_row[col_reg] = val_reg;
    end

    // Drive the write port
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = row_reg;
        mem_wdata = cell_row;
        if (state_reg == lag_pkg::ST_CELL)
        begin
            mem_we = op_write_reg;
        end
        else if ((state_reg == lag_pkg::ST_GEN) && (gen_cnt_reg >= CW'(3)))
        begin
            mem_we    = 1'b1;
            mem_waddr = AW'(gen_cnt_reg - CW'(3));
            mem_wdata = new_row;
        end
    end

    // Sequencer and result staging
    always_comb
    begin
        state_next       = state_reg;
        gen_cnt_next     = gen_cnt_reg;
        res_pending_next = res_pending_reg;
        res_state_next   = res_state_reg;
        res_done_next    = res_done_reg;
        op_write_next    = op_write_reg;
        row_next         = row_reg;
        col_next         = col_reg;
        val_next         = val_reg;
        prev_next        = prev_reg;
        cur_next         = cur_reg;
        row0_next        = row0_reg;
        out_valid_next   = out_valid_reg;
        out_state_next   = out_state_reg;
        out_done_next    = out_done_reg;

        case (state_reg)
            lag_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    case (func_in)
                        lag_pkg::FUNC_WRITE, lag_pkg::FUNC_READ:
                        begin
                            if (on_grid)
                            begin
                                state_next    = lag_pkg::ST_CELL;
                                op_write_next = (func_in == lag_pkg::FUNC_WRITE);
                                row_next      = AW'(row_in);
                                col_next      = AW'(col_in);
                                val_next      = val_in;
                            end
                            else
                            begin
                                res_pending_next = 1'b1;
                                res_state_next   = 1'b0;
                                res_done_next    = 1'b0;
                            end
                        end
                        lag_pkg::FUNC_ADVANCE:
                        begin
                            state_next   = lag_pkg::ST_GEN;
                            gen_cnt_next = '0;
                        end
                        default:
                        begin
                            res_pending_next = 1'b1;
                            res_state_next   = 1'b0;
                            res_done_next    = 1'b0;
                        end
                    endcase
                end
            end
            lag_pkg::ST_CELL:
            begin
                state_next       = lag_pkg::ST_IDLE;
                res_pending_next = 1'b1;
                res_state_next   = op_write_reg ? 1'b0 : row_data[col_reg];
                res_done_next    = 1'b1;
            end
            lag_pkg::ST_GEN:
            begin
                gen_cnt_next = gen_cnt_reg + CW'(1);
                if (gen_cnt_reg == CW'(1))
                begin
                    prev_next = row_data;
                end
                else if (gen_cnt_reg == CW'(2))
                begin
                    cur_next  = row_data;
                    row0_next = row_data;
                end
                else if (gen_cnt_reg >= CW'(3))
                begin
                    prev_next = cur_reg;
                    cur_next  = next_row;
                end
                if (gen_cnt_reg == GEN_LAST)
                begin
                    state_next       = lag_pkg::ST_IDLE;
                    res_pending_next = 1'b1;
                    res_state_next   = 1'b0;
                    res_done_next    = 1'b1;
                end
            end
            default:
            begin
                state_next = lag_pkg::ST_IDLE;
            end
        endcase

        // Move a staged result into the output register once it is free
        if (res_pending_reg && (!out_valid_reg || m_axis_tready))
        begin
            out_valid_next   = 1'b1;
            out_state_next   = res_state_reg;
            out_done_next    = res_done_reg;
            res_pending_next = 1'b0;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= lag_pkg::ST_IDLE;
            gen_cnt_reg     <= '0;
            res_pending_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
            rd_valid_reg    <= 1'b0;
            valid_reg       <= '0;
            rule_reg.lonely <= lag_pkg::LONELY_RESET;
            rule_reg.crowd  <= lag_pkg::CROWD_RESET;
            rule_reg.birth  <= lag_pkg::BIRTH_RESET;
        end
        else
        begin
            state_reg       <= state_next;
            gen_cnt_reg     <= gen_cnt_next;
            res_pending_reg <= res_pending_next;
            out_valid_reg   <= out_valid_next;
            rd_valid_reg    <= valid_reg[mem_raddr];
            if (mem_we)
            begin
                valid_reg[mem_waddr] <= 1'b1;
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    lag_pkg::CFG_LONELY: rule_reg.lonely <= cfg_data;
                    lag_pkg::CFG_CROWD:  rule_reg.crowd  <= cfg_data;
                    lag_pkg::CFG_BIRTH:  rule_reg.birth  <= cfg_data;
                    default:             rule_reg        <= rule_reg;
                endcase
            end
        end
    end

    // Payload state
    always_ff @(posedge clk)
    begin
        op_write_reg  <= op_write_next;
        row_reg       <= row_next;
        col_reg       <= col_next;
        val_reg       <= val_next;
        res_state_reg <= res_state_next;
        res_done_reg  <= res_done_next;
        out_state_reg <= out_state_next;
        out_done_reg  <= out_done_next;
        prev_reg      <= prev_next;
        cur_reg       <= cur_next;
        row0_reg      <= row0_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {6'b0, out_done_reg, out_state_reg};

    // The grid is only written by a running cell or generation step
    assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (state_reg != lag_pkg::ST_IDLE))
        else $error("grid written while idle");

    // The sweep never reads a row in the cycle it rewrites it
    assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == lag_pkg::ST_GEN) && mem_we && (gen_cnt_reg <= GEN_SIDE))
        |-> (mem_raddr != mem_waddr))
        else $error("generation read and write hit the same row");

    // A completed generation leaves every row written and a result staged
    assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == lag_pkg::ST_GEN) && (gen_cnt_reg == GEN_LAST))
        |=> ((&valid_reg) && res_pending_reg && (state_reg == lag_pkg::ST_IDLE)))
        else $error("generation ended without covering the grid");

    // No request is taken while a result is still staged
    assert property (@(posedge clk) disable iff (!rst_n)
        res_pending_reg |-> !s_axis_tready)
        else $error("request accepted over a staged result");

endmodule

`default_nettype wire
